// ----- rtl/core/cdc_pkg.sv -----
// ----------------------------------------------------------------------------
// cdc_pkg: calendar date counter shared definitions
// Field widths, command codes, request/result types and month length helpers.
// ----------------------------------------------------------------------------
package cdc_pkg;

    localparam int MODE_W  = 2;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    // Year kept as (year mod 100, (year / 100) mod 4) for the leap rule.
    localparam int C100_W = 7;
    localparam int Q4_W   = 2;

    localparam int MAX_YEAR       = 9999;
    localparam int YEAR_FIELD_MAX = (1 << YEAR_W) - 1;
    localparam logic [YEAR_W-1:0] TOP_YEAR =
        YEAR_W'((MAX_YEAR > YEAR_FIELD_MAX) ? YEAR_FIELD_MAX : MAX_YEAR);

    // floor(y / 100) = (y * 5243) >> 19, exact for any 14-bit y
    localparam int DIV100_MUL_W = 13;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
    localparam int DIV100_SHIFT = 19;
    localparam int PROD_W       = YEAR_W + DIV100_MUL_W;
    localparam int QUO_W        = PROD_W - DIV100_SHIFT;
    localparam logic [C100_W-1:0] LAST_C100 = 7'd99;
    localparam logic [YEAR_W-1:0] CENTURY   = 14'd100;

    // Reset date 2000-01-01
    localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2000;
    localparam logic [C100_W-1:0]  RST_C100  = 7'd0;
    localparam logic [Q4_W-1:0]    RST_Q4    = 2'd0;

    // Commands
    localparam logic [MODE_W-1:0] MODE_HOLD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEXT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PREV = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd3;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0] DAYS_28   = 5'd28;
    localparam logic [DAY_W-1:0] DAYS_29   = 5'd29;
    localparam logic [DAY_W-1:0] DAYS_30   = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_31   = 5'd31;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [YEAR_W-1:0]  load_year;
        logic [MONTH_W-1:0] load_month;
        logic [DAY_W-1:0]   load_day;
    } t_req;

    typedef struct packed {
        logic [YEAR_W-1:0]  cur_year;
        logic [MONTH_W-1:0] cur_month;
        logic [DAY_W-1:0]   cur_day;
        logic               month_end;
        logic               year_end;
        logic               leap;
        logic               load_rejected;
        logic               limit_reached;
    } t_rsp;

    // Decoded request handed to the date step stage
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               ok;
        logic [C100_W-1:0]  c100;
        logic [Q4_W-1:0]    q4;
    } t_ld;

    // Pipeline control from the top level
    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

    function automatic logic f_leap(input logic [C100_W-1:0] c100,
                                    input logic [Q4_W-1:0] q4);
        f_leap = (c100[1:0] == 2'd0) && ((c100 != '0) || (q4 == '0));
    endfunction

    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        len = DAYS_31;
        if (month == MONTH_FEB) begin
            len = leap ? DAYS_29 : DAYS_28;
        end else if (month inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
            len = DAYS_30;
        end
        f_month_len = len;
    endfunction

endpackage

// ----- rtl/core/cdc_if.sv -----
// ----------------------------------------------------------------------------
// cdc_if: request and result channels
// Valid/ready channels carrying the command request and the date result.
// ----------------------------------------------------------------------------
interface cdc_req_if;
    import cdc_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cdc_rsp_if;
    import cdc_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/cdc_ldec.sv -----
// ----------------------------------------------------------------------------
// cdc_ldec: request register and load decode
// Registers the request, splits the load year by 100 and checks the load date.
// ----------------------------------------------------------------------------
module cdc_ldec (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cdc_pkg::t_ctl  i_ctl,
    input  cdc_pkg::t_req  i_req,
    output logic           o_valid,
    output cdc_pkg::t_ld   o_ld
);
    import cdc_pkg::*;

    logic               r_valid_in;
    t_req               r_req;
    logic               r_valid_ld;
    t_ld                r_ld;
    t_ld                n_ld;

    logic [PROD_W-1:0]  prod;
    logic [QUO_W-1:0]   quo;
    logic [YEAR_W-1:0]  rem;
    logic               ld_leap;
    logic               month_ok;
    logic               day_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_in <= 1'b0;
            r_valid_ld <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid_in <= i_ctl.valid;
            r_valid_ld <= r_valid_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_req <= i_req;
            r_ld  <= n_ld;
        end
    end

    always_comb begin
        prod     = PROD_W'(r_req.load_year) * PROD_W'(DIV100_MUL);
        quo      = prod[PROD_W-1:DIV100_SHIFT];
        rem      = r_req.load_year - YEAR_W'(YEAR_W'(quo) * CENTURY);
        ld_leap  = f_leap(rem[C100_W-1:0], quo[Q4_W-1:0]);
        month_ok = (r_req.load_month >= MONTH_JAN) && (r_req.load_month <= MONTH_DEC);
        day_ok   = (r_req.load_day >= DAY_FIRST) &&
                   (r_req.load_day <= f_month_len(r_req.load_month, ld_leap));

        n_ld.mode  = r_req.mode;
        n_ld.year  = r_req.load_year;
        n_ld.month = r_req.load_month;
        n_ld.day   = r_req.load_day;
        n_ld.ok    = (r_req.load_year <= TOP_YEAR) && month_ok && day_ok;
        n_ld.c100  = rem[C100_W-1:0];
        n_ld.q4    = quo[Q4_W-1:0];
    end

    assign o_valid = r_valid_ld;
    assign o_ld    = r_ld;

endmodule

// ----- rtl/core/cdc_step.sv -----
// ----------------------------------------------------------------------------
// cdc_step: date state and result register
// Applies hold/next/previous/load to the stored date and registers the result.
// ----------------------------------------------------------------------------
module cdc_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  cdc_pkg::t_ld   i_ld,
    output logic           o_valid,
    output cdc_pkg::t_rsp  o_rsp
);
    import cdc_pkg::*;

    logic [YEAR_W-1:0]  r_year,  n_year;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [DAY_W-1:0]   r_day,   n_day;
    logic [C100_W-1:0]  r_c100,  n_c100;
    logic [Q4_W-1:0]    r_q4,    n_q4;
    logic               r_valid;
    t_rsp               r_rsp,   n_rsp;

    logic               cur_leap;
    logic [DAY_W-1:0]   cur_len;
    logic               n_leap;
    logic               rejected;
    logic               limit;

    always_comb begin
        cur_leap = f_leap(r_c100, r_q4);
        cur_len  = f_month_len(r_month, cur_leap);
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_c100   = r_c100;
        n_q4     = r_q4;
        rejected = 1'b0;
        limit    = 1'b0;

        case (i_ld.mode)
            MODE_NEXT: begin
                if (r_day >= cur_len) begin
                    if (r_month >= MONTH_DEC) begin
                        if (r_year >= TOP_YEAR) begin
                            limit = 1'b1;
                        end else begin
                            n_year  = r_year + 1'b1;
                            n_month = MONTH_JAN;
                            n_day   = DAY_FIRST;
                            if (r_c100 == LAST_C100) begin
                                n_c100 = '0;
                                n_q4   = r_q4 + 1'b1;
                            end else begin
                                n_c100 = r_c100 + 1'b1;
                            end
                        end
                    end else begin
                        n_month = r_month + 1'b1;
                        n_day   = DAY_FIRST;
                    end
                end else begin
                    n_day = r_day + 1'b1;
                end
            end
            MODE_PREV: begin
                if (r_day <= DAY_FIRST) begin
                    if (r_month <= MONTH_JAN) begin
                        if (r_year == '0) begin
                            limit = 1'b1;
                        end else begin
                            n_year  = r_year - 1'b1;
                            n_month = MONTH_DEC;
                            n_day   = DAYS_31;
                            if (r_c100 == '0) begin
                                n_c100 = LAST_C100;
                                n_q4   = r_q4 - 1'b1;
                            end else begin
                                n_c100 = r_c100 - 1'b1;
                            end
                        end
                    end else begin
                        n_month = r_month - 1'b1;
                        n_day   = f_month_len(r_month - 1'b1, cur_leap);
                    end
                end else begin
                    n_day = r_day - 1'b1;
                end
            end
            MODE_LOAD: begin
                if (i_ld.ok) begin
                    n_year  = i_ld.year;
                    n_month = i_ld.month;
                    n_day   = i_ld.day;
                    n_c100  = i_ld.c100;
                    n_q4    = i_ld.q4;
                end else begin
                    rejected = 1'b1;
                end
            end
            default: begin
                // hold: date unchanged
            end
        endcase

        n_leap              = f_leap(n_c100, n_q4);
        n_rsp.cur_year      = n_year;
        n_rsp.cur_month     = n_month;
        n_rsp.cur_day       = n_day;
        n_rsp.month_end     = (n_day == f_month_len(n_month, n_leap));
        n_rsp.year_end      = (n_month == MONTH_DEC) && (n_day == DAYS_31);
        n_rsp.leap          = n_leap;
        n_rsp.load_rejected = rejected;
        n_rsp.limit_reached = limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= RST_YEAR;
            r_month <= MONTH_JAN;
            r_day   <= DAY_FIRST;
            r_c100  <= RST_C100;
            r_q4    <= RST_Q4;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_year  <= n_year;
                r_month <= n_month;
                r_day   <= n_day;
                r_c100  <= n_c100;
                r_q4    <= n_q4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ----- rtl/core/calendar_date_up_down_counter_top.sv -----
// ----------------------------------------------------------------------------
// calendar_date_up_down_counter_top: Gregorian date up/down counter
// Holds a date and applies hold, next day, previous day or load per request.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Payload                                 | Handshake
//  ---------+-----+-----------------------------------------+-------------
//  i_req    | in  | mode, load_year, load_month, load_day   | valid/ready
//  o_rsp    | out | date, month/year end, leap, rej, limit  | valid/ready
//
//  One request per cycle sustained while o_rsp is not held off; each request
//  passes through the request, load decode and result registers in order.
//  The stored date is updated only in the date step stage, so consecutive
//  requests see each other's result with no bubble.
//  When o_rsp is held off, the whole pipe freezes and i_req.ready drops.
//  Reset (synchronous, active low) sets the date to 2000-01-01 and empties
//  the pipe.
//
module calendar_date_up_down_counter_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cdc_req_if.sink      i_req,
    cdc_rsp_if.source    o_rsp
);
    import cdc_pkg::*;

    t_ctl  pipe_ctl;
    logic  ld_valid;
    t_ld   ld;
    logic  step_valid;
    t_rsp  step_rsp;
    logic  pipe_en;

    // Pipe advances whenever the result register is empty or being drained.
    assign pipe_en        = !step_valid || o_rsp.ready;
    assign pipe_ctl.en    = pipe_en;
    assign pipe_ctl.valid = i_req.valid;
    assign i_req.ready    = pipe_en;

    // Stage 1-2: request register, then load year split and date check
    cdc_ldec u_ldec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pipe_ctl),
        .i_req   (i_req.data),
        .o_valid (ld_valid),
        .o_ld    (ld)
    );

    // Stage 3: date state update and result register
    cdc_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (ld_valid),
        .i_ld    (ld),
        .o_valid (step_valid),
        .o_rsp   (step_rsp)
    );

    assign o_rsp.valid = step_valid;
    assign o_rsp.data  = step_rsp;

endmodule

// ----- rtl/core/cdc_chk.sv -----
// ----------------------------------------------------------------------------
// cdc_chk: port level checks for the date counter
// Watches the top level channels; attached by bind.
// ----------------------------------------------------------------------------
module cdc_chk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  cdc_pkg::t_rsp  i_out_data
);
    import cdc_pkg::*;

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // Empty output side never blocks requests
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request blocked with empty result register");

    // Result month in 1..12, day at least 1 and year at most TOP_YEAR
    a_date_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.cur_month >= MONTH_JAN) &&
                        (i_out_data.cur_month <= MONTH_DEC) &&
                        (i_out_data.cur_day >= DAY_FIRST) &&
                        (i_out_data.cur_year <= TOP_YEAR))
        else $error("illegal date in result");

    // December 31 is always a month end
    a_year_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.year_end |-> i_out_data.month_end)
        else $error("year end without month end");

    // A load rejection and a range limit cannot come from one request
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.load_rejected && i_out_data.limit_reached))
        else $error("rejected and limit flags both set");

endmodule

bind calendar_date_up_down_counter_top cdc_chk u_cdc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data)
);
